// ----- rtl/hdr_pixel_clamp_normalize_assert.svh -----
// ----------------------------------------------------------------------------
// hdr_pixel_clamp_normalize_assert
// Assertion macros for the pixel clamp RTL.
// ----------------------------------------------------------------------------
`ifndef HDR_PIXEL_CLAMP_NORMALIZE_ASSERT_SVH
`define HDR_PIXEL_CLAMP_NORMALIZE_ASSERT_SVH

// implication checked every cycle outside reset
`define HPCN_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define HPCN_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hpcn_pkg.sv -----
// ----------------------------------------------------------------------------
// hpcn_pkg
// Shared types, class codes and channel decode for the pixel clamp block.
// ----------------------------------------------------------------------------
package hpcn_pkg;

    localparam logic [2:0] CLASS_PASS   = 3'd0;
    localparam logic [2:0] CLASS_SCALED = 3'd1;
    localparam logic [2:0] CLASS_NEG    = 3'd2;
    localparam logic [2:0] CLASS_INF    = 3'd3;
    localparam logic [2:0] CLASS_NAN    = 3'd4;

    localparam logic [62:0] MAG_255 = 63'h406F_E000_0000_0000;

    typedef struct packed {
        logic        is_nan;
        logic        is_inf;
        logic        is_neg;
        logic [62:0] mag;
    } chan_t;

    typedef struct packed {
        logic [2:0]  cls;
        logic [62:0] kmag;
    } merge_t;

    function automatic chan_t chan_decode(input logic [63:0] bits);
        chan_t c;
        c.mag    = bits[62:0];
        c.is_nan = (bits[62:52] == 11'h7FF) && (bits[51:0] != 52'd0);
        c.is_inf = (bits[62:52] == 11'h7FF) && (bits[51:0] == 52'd0);
        c.is_neg = (bits[62:52] != 11'h7FF) && bits[63] && (bits[62:0] != 63'd0);
        return c;
    endfunction

endpackage

// ----- rtl/hdr_pixel_clamp_normalize.sv -----
// ----------------------------------------------------------------------------
// hdr_pixel_clamp_normalize
// Classifies an HDR pixel, clamps or rescales it to unsigned fixed point and
// keeps saturating per-class counters.
// A pixel passes the merge, start and run states; scaled pixels stay in run
// until the bit-serial divider in each lane is done. The next pixel is accepted
// only after the previous result is loaded, which output stalls can delay; it
// is accepted while a result waits in the output register.
// Reset: synchronous active-low aresetn clears control state and counters.
// ----------------------------------------------------------------------------
module hdr_pixel_clamp_normalize
    import hpcn_pkg::*;
#(
    parameter int COUNT_WIDTH   = 32,
    parameter int FRACTION_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_red_bits,
    input  logic [63:0] s_green_bits,
    input  logic [63:0] s_blue_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_red_level,
    output logic [15:0] m_green_level,
    output logic [15:0] m_blue_level,
    output logic [2:0]  m_pixel_class,
    output logic [31:0] m_scaled_total,
    output logic [31:0] m_negative_total,
    output logic [31:0] m_infinite_total,
    output logic [31:0] m_nan_total
);

    `include "hdr_pixel_clamp_normalize_assert.svh"

    localparam int QW = FRACTION_BITS + 9;
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MERGE = 2'd1;
    localparam logic [1:0] S_START = 2'd2;
    localparam logic [1:0] S_RUN   = 2'd3;
    localparam logic [QW-1:0] LVL_FULL = QW'(255) << FRACTION_BITS;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [1:0]  state_reg, state_next;
    logic [63:0] red_reg, green_reg, blue_reg;
    chan_t       chan_r, chan_g, chan_b;
    merge_t      merged, merge_reg;

    logic [2:0]    lane_done;
    logic [QW-1:0] lvl_r, lvl_g, lvl_b;
    logic          lane_start, lane_scaled, load_out;

    logic                   m_valid_reg;
    logic [15:0]            red_out_reg, green_out_reg, blue_out_reg;
    logic [2:0]             class_out_reg;
    logic [COUNT_WIDTH-1:0] scaled_cnt_reg, neg_cnt_reg, inf_cnt_reg, nan_cnt_reg;
    logic [QW-1:0]          sel_r, sel_g, sel_b;

    always_comb begin
        chan_r = chan_decode(red_reg);
        chan_g = chan_decode(green_reg);
        chan_b = chan_decode(blue_reg);
    end

    hpcn_merge u_merge (
        .chan_r (chan_r),
        .chan_g (chan_g),
        .chan_b (chan_b),
        .merged (merged)
    );

    assign lane_start  = (state_reg == S_START);
    assign lane_scaled = (merge_reg.cls == CLASS_SCALED);

    hpcn_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_r (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start), .scaled(lane_scaled),
        .mag(chan_r.mag), .kmag(merge_reg.kmag), .done(lane_done[0]), .level(lvl_r)
    );
    hpcn_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_g (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start), .scaled(lane_scaled),
        .mag(chan_g.mag), .kmag(merge_reg.kmag), .done(lane_done[1]), .level(lvl_g)
    );
    hpcn_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_b (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start), .scaled(lane_scaled),
        .mag(chan_b.mag), .kmag(merge_reg.kmag), .done(lane_done[2]), .level(lvl_b)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_RUN) && (&lane_done) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_MERGE;
            S_MERGE: state_next = S_START;
            S_START: state_next = S_RUN;
            S_RUN:   if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        case (merge_reg.cls)
            CLASS_NAN, CLASS_NEG: begin
                sel_r = '0;
                sel_g = '0;
                sel_b = '0;
            end
            CLASS_INF: begin
                sel_r = LVL_FULL;
                sel_g = LVL_FULL;
                sel_b = LVL_FULL;
            end
            default: begin
                sel_r = lvl_r;
                sel_g = lvl_g;
                sel_b = lvl_b;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            scaled_cnt_reg <= '0;
            neg_cnt_reg    <= '0;
            inf_cnt_reg    <= '0;
            nan_cnt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
                case (merge_reg.cls)
                    CLASS_SCALED: if (scaled_cnt_reg != CNT_MAX)
                        scaled_cnt_reg <= scaled_cnt_reg + 1'b1;
                    CLASS_NEG:    if (neg_cnt_reg != CNT_MAX)
                        neg_cnt_reg <= neg_cnt_reg + 1'b1;
                    CLASS_INF:    if (inf_cnt_reg != CNT_MAX)
                        inf_cnt_reg <= inf_cnt_reg + 1'b1;
                    CLASS_NAN:    if (nan_cnt_reg != CNT_MAX)
                        nan_cnt_reg <= nan_cnt_reg + 1'b1;
                    default: ;
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            red_reg   <= s_red_bits;
            green_reg <= s_green_bits;
            blue_reg  <= s_blue_bits;
        end
        if (state_reg == S_MERGE) begin
            merge_reg <= merged;
        end
        if (load_out) begin
            red_out_reg   <= 16'(sel_r);
            green_out_reg <= 16'(sel_g);
            blue_out_reg  <= 16'(sel_b);
            class_out_reg <= merge_reg.cls;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_red_level      = red_out_reg;
    assign m_green_level    = green_out_reg;
    assign m_blue_level     = blue_out_reg;
    assign m_pixel_class    = class_out_reg;
    assign m_scaled_total   = 32'(64'(scaled_cnt_reg));
    assign m_negative_total = 32'(64'(neg_cnt_reg));
    assign m_infinite_total = 32'(64'(inf_cnt_reg));
    assign m_nan_total      = 32'(64'(nan_cnt_reg));

    `HPCN_ASSERT_IMP(a_black_levels, aclk, aresetn,
        m_valid && (m_pixel_class == CLASS_NAN || m_pixel_class == CLASS_NEG),
        m_red_level == 16'd0 && m_green_level == 16'd0 && m_blue_level == 16'd0,
        "black class with nonzero level")
    `HPCN_ASSERT_IMP(a_full_levels, aclk, aresetn,
        m_valid && m_pixel_class == CLASS_INF,
        m_red_level == 16'(LVL_FULL) && m_blue_level == 16'(LVL_FULL),
        "infinite class without full level")
    `HPCN_ASSERT_NEXT(a_counts_hold, aclk, aresetn, !load_out,
        $stable(nan_cnt_reg) && $stable(scaled_cnt_reg),
        "counter moved without a result")
    `HPCN_ASSERT_IMP(a_load_in_run, aclk, aresetn, load_out,
        !s_ready && (&lane_done),
        "result loaded outside run state")

endmodule

// ----- rtl/hpcn_merge.sv -----
// ----------------------------------------------------------------------------
// hpcn_merge
// Combines the three channel decodes into the pixel class and largest magnitude.
// ----------------------------------------------------------------------------
module hpcn_merge
    import hpcn_pkg::*;
(
    input  chan_t  chan_r,
    input  chan_t  chan_g,
    input  chan_t  chan_b,
    output merge_t merged
);

    logic [62:0] max_rg;

    always_comb begin
        max_rg      = (chan_g.mag > chan_r.mag) ? chan_g.mag : chan_r.mag;
        merged.kmag = (chan_b.mag > max_rg) ? chan_b.mag : max_rg;
        if (chan_r.is_nan || chan_g.is_nan || chan_b.is_nan) begin
            merged.cls = CLASS_NAN;
        end else if (chan_r.is_inf || chan_g.is_inf || chan_b.is_inf) begin
            merged.cls = CLASS_INF;
        end else if (chan_r.is_neg || chan_g.is_neg || chan_b.is_neg) begin
            merged.cls = CLASS_NEG;
        end else if (merged.kmag > MAG_255) begin
            merged.cls = CLASS_SCALED;
        end else begin
            merged.cls = CLASS_PASS;
        end
    end

endmodule

// ----- rtl/hpcn_lane.sv -----
// ----------------------------------------------------------------------------
// hpcn_lane
// One channel: direct fixed-point conversion, or restoring division by the
// largest channel, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hpcn_lane #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic                      scaled,
    input  logic [62:0]               mag,
    input  logic [62:0]               kmag,
    output logic                      done,
    output logic [FRACTION_BITS+8:0]  level
);

    localparam int QW = FRACTION_BITS + 9;
    localparam int AW = 61 + FRACTION_BITS;
    localparam int CW = 63 + FRACTION_BITS;
    localparam int PW = 53 + FRACTION_BITS;
    localparam int JW = $clog2(QW);

    logic [10:0]   evx, ekx;
    logic [52:0]   mv, mk;
    logic [11:0]   dshift;
    logic [AW-1:0] n255, num;
    logic [PW-1:0] plain;
    logic [CW-1:0] trial;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [JW-1:0] j_reg, j_next;
    logic [CW-1:0] r_reg, r_next;
    logic [QW-1:0] q_reg, q_next;

    always_comb begin
        evx    = (mag[62:52] == 11'd0) ? 11'd1 : mag[62:52];
        ekx    = (kmag[62:52] == 11'd0) ? 11'd1 : kmag[62:52];
        mv     = {mag[62:52] != 11'd0, mag[51:0]};
        mk     = {kmag[62:52] != 11'd0, kmag[51:0]};
        dshift = {1'b0, ekx} - {1'b0, evx};
        n255   = (AW'(mv) << 8) - AW'(mv);
        num    = n255 << FRACTION_BITS;
        plain  = (PW'(mv) << FRACTION_BITS) >> (12'd1075 - {1'b0, evx});
        trial  = CW'(mk) << j_reg;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        j_next    = j_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        if (start) begin
            j_next = JW'(QW - 1);
            if (scaled) begin
                busy_next = 1'b1;
                done_next = 1'b0;
                r_next    = CW'(num >> dshift);
                q_next    = '0;
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
                q_next    = QW'(plain);
            end
        end else if (busy_reg) begin
            if (r_reg >= trial) begin
                r_next        = r_reg - trial;
                q_next[j_reg] = 1'b1;
            end
            if (j_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                j_next = j_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        j_reg <= j_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign done  = done_reg;
    assign level = q_reg;

endmodule

// ----- tb/hdr_pixel_clamp_normalize_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_pixel_clamp_normalize_test
// Drives binary64 RGB pixels through the clamp/normalize block with random
// gaps and output stalls, predicts each pixel's levels, class and saturating
// class totals, and checks every result word in order.
// ----------------------------------------------------------------------------
module hdr_pixel_clamp_normalize_test
    import hpcn_pkg::*;
();

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [2:0]  cls;
        logic [31:0] scaled;
        logic [31:0] negative;
        logic [31:0] infinite;
        logic [31:0] nan;
    } pixel_out_t;

    int unsigned error_count = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        error_count++;
    endtask

    class pixel_scoreboard;
        pixel_out_t  pending[$];
        logic [31:0] scaled_cnt, negative_cnt, infinite_cnt, nan_cnt;

        function new();
            scaled_cnt = 0; negative_cnt = 0; infinite_cnt = 0; nan_cnt = 0;
        endfunction

        static function logic [31:0] bump(logic [31:0] c);
            return (c == 32'hFFFF_FFFF) ? c : c + 1;
        endfunction

        static function logic [63:0] mantissa(logic [62:0] mag, output int e);
            if (mag[62:52] == 0) begin
                e = -1074;
                return {12'd0, mag[51:0]};
            end
            e = int'(mag[62:52]) - 1075;
            return {11'd0, 1'b1, mag[51:0]};
        endfunction

        static function logic [15:0] plain_level(logic [62:0] mag);
            int e, t;
            logic [63:0] m;
            m = mantissa(mag, e);
            t = e + 8;
            if (t >= 0) return (t < 40) ? 16'(m << t) : 16'd0;
            if (-t >= 64) return 16'd0;
            return 16'(m >> (-t));
        endfunction

        static function logic [15:0] scaled_level(logic [62:0] mag, logic [62:0] kmag);
            int ev, ek, s;
            logic [63:0] mv, mk;
            logic [127:0] n;
            mv = mantissa(mag, ev);
            mk = mantissa(kmag, ek);
            n = 128'(mv) * 255;
            s = 8 + ev - ek;
            if (s < 0) begin
                if (-s >= 64) return 16'd0;
                return 16'((n >> (-s)) / mk);
            end
            return 16'((n << s) / mk);
        endfunction

        function void note_pixel(logic [63:0] r, logic [63:0] g, logic [63:0] b);
            logic [63:0] ch[3];
            logic [62:0] kmag;
            logic [15:0] lv[3];
            bit any_nan, any_inf, any_neg;
            pixel_out_t p;
            ch[0] = r; ch[1] = g; ch[2] = b;
            kmag = 0; any_nan = 0; any_inf = 0; any_neg = 0;
            foreach (ch[i]) begin
                if (ch[i][62:52] == 11'h7FF) begin
                    if (ch[i][51:0] != 0) any_nan = 1; else any_inf = 1;
                end else if (ch[i][63] && ch[i][62:0] != 0) any_neg = 1;
                if (ch[i][62:0] > kmag) kmag = ch[i][62:0];
            end
            if (any_nan) begin
                p.cls = CLASS_NAN; nan_cnt = bump(nan_cnt);
                lv = '{0, 0, 0};
            end else if (any_inf) begin
                p.cls = CLASS_INF; infinite_cnt = bump(infinite_cnt);
                lv = '{16'hFF00, 16'hFF00, 16'hFF00};
            end else if (any_neg) begin
                p.cls = CLASS_NEG; negative_cnt = bump(negative_cnt);
                lv = '{0, 0, 0};
            end else if (kmag > MAG_255) begin
                p.cls = CLASS_SCALED; scaled_cnt = bump(scaled_cnt);
                foreach (lv[i]) lv[i] = scaled_level(ch[i][62:0], kmag);
            end else begin
                p.cls = CLASS_PASS;
                foreach (lv[i]) lv[i] = plain_level(ch[i][62:0]);
            end
            p.red = lv[0]; p.green = lv[1]; p.blue = lv[2];
            p.scaled = scaled_cnt; p.negative = negative_cnt;
            p.infinite = infinite_cnt; p.nan = nan_cnt;
            pending.push_back(p);
        endfunction

        task check_pixel(pixel_out_t got);
            pixel_out_t w;
            if (pending.size() == 0) begin
                report("unexpected word", 0, 0);
                return;
            end
            w = pending.pop_front();
            if (got.red != w.red) report("red_level", got.red, w.red);
            if (got.green != w.green) report("green_level", got.green, w.green);
            if (got.blue != w.blue) report("blue_level", got.blue, w.blue);
            if (got.cls != w.cls) report("pixel_class", got.cls, w.cls);
            if (got.scaled != w.scaled) report("scaled_total", got.scaled, w.scaled);
            if (got.negative != w.negative)
                report("negative_total", got.negative, w.negative);
            if (got.infinite != w.infinite)
                report("infinite_total", got.infinite, w.infinite);
            if (got.nan != w.nan) report("nan_total", got.nan, w.nan);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [63:0] s_red_bits = 0, s_green_bits = 0, s_blue_bits = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_red_level, m_green_level, m_blue_level;
    logic [2:0]  m_pixel_class;
    logic [31:0] m_scaled_total, m_negative_total, m_infinite_total, m_nan_total;

    pixel_scoreboard board = new();

    hdr_pixel_clamp_normalize dut (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // accepted words and delivered results, scored at the edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_pixel(s_red_bits, s_green_bits, s_blue_bits);
        if (aresetn && m_valid && m_ready)
            board.check_pixel('{m_red_level, m_green_level, m_blue_level, m_pixel_class,
                                m_scaled_total, m_negative_total, m_infinite_total,
                                m_nan_total});
    end

    // result stalls, with quiet stretches
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 9) < 3) begin
                m_ready <= 1;
                repeat ($urandom_range(20, 80)) @(posedge aclk);
            end
            n = gap_len();
            m_ready <= (n == 0);
            repeat (n) @(posedge aclk);
            m_ready <= 1;
        end
    end

    task automatic send_pixel(input logic [63:0] r, input logic [63:0] g, input logic [63:0] b);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_valid <= 0;
            repeat (n) @(posedge aclk);
        end
        s_valid      <= 1;
        s_red_bits   <= r;
        s_green_bits <= g;
        s_blue_bits  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [63:0] rand_chan();
        logic [63:0] v;
        int k;
        v = {$urandom, $urandom};
        k = $urandom_range(0, 99);
        if (k < 40) v[62:52] = 11'($urandom_range(1000, 1040));
        else if (k < 48) v[62:52] = 0;
        else if (k < 52) v[62:52] = 11'h7FF;
        else if (k < 56) v[62:0] = 0;
        else if (k < 60) v[62:0] = 63'(MAG_255) + 63'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 9) < 8) v[63] = 0;
        return v;
    endfunction

    localparam logic [63:0] F255 = 64'h406F_E000_0000_0000;
    localparam logic [63:0] PINF = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] QNAN = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] ONE  = 64'h3FF0_0000_0000_0000;

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_pixel(0, 0, 0);
        send_pixel(ONE, F255, 64'h3FE0_0000_0000_0000);
        send_pixel(F255, F255, F255);
        send_pixel(F255 + 1, ONE, 0);
        send_pixel(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001, F255);
        send_pixel(64'h8000_0000_0000_0000, ONE, ONE);
        send_pixel(64'h8000_0000_0000_0001, ONE, ONE);
        send_pixel(64'hBFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF, 0);
        send_pixel(PINF, ONE, ONE);
        send_pixel(ONE, 64'hFFF0_0000_0000_0000, 64'hBFF0_0000_0000_0000);
        send_pixel(QNAN, PINF, ONE);
        send_pixel(ONE, ONE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_pixel(64'h7FF0_0000_0000_0001, ONE, ONE);
        send_pixel(64'h000F_FFFF_FFFF_FFFF, 64'h3F70_0000_0000_0000, ONE);
        send_pixel(64'h4070_0000_0000_0000, 64'h4060_0000_0000_0000, 64'h000F_FFFF_FFFF_FFFF);
        send_pixel(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        // hold off until the pipeline drains
        s_valid <= 0;
        @(negedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        for (int i = 0; i < 1630; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan());
        s_valid <= 0;
        @(negedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (error_count == 0)
            $display("hdr_pixel_clamp_normalize regression: pass");
        else
            $display("hdr_pixel_clamp_normalize regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("hdr_pixel_clamp_normalize regression: fail");
        $finish;
    end
endmodule

// ----- hdr_pixel_clamp_normalize.f -----
+incdir+rtl
rtl/hpcn_pkg.sv
rtl/hpcn_merge.sv
rtl/hpcn_lane.sv
rtl/hdr_pixel_clamp_normalize.sv
tb/hdr_pixel_clamp_normalize_test.sv
